@@ hdl/first_fit_partition_allocator_assert.svh @@
// Assertion macros for the first-fit partition allocator
`ifndef FIRST_FIT_PARTITION_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_PARTITION_ALLOCATOR_ASSERT_SVH

// a condition implies a consequence in the same cycle
`define FFPA_ASSERT_IMP(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// a condition implies a consequence in the next cycle
`define FFPA_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

@@ hdl/ffpa_pkg.sv @@
package ffpa_pkg;

  localparam int unsigned AddrW = 16;
  localparam logic [AddrW-1:0] ResetTotal = 16'd640;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_NO_MATCH = 2'd2,
    ST_BAD      = 2'd3
  } status_t;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture request
    logic scan_step;   // advance scan index
    logic scan_reset;  // restart scan index at zero
    logic alloc_apply; // alloc commit (insert used, adjust free)
    logic free_apply;  // free commit (remove used, insert/merge free)
    logic latch_hit;   // latch the scan hit index
  } ffpa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;   // scan index reached count
    logic scan_hit;    // current entry matches
    logic used_full;
    logic size_zero;
    logic is_free;
  } ffpa_sts_t;

endpackage

@@ hdl/ffpa_datapath.sv @@
// Table storage and the scan/shift datapath
module ffpa_datapath #(
  parameter int unsigned MaxParts = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [15:0]            cfg_data,
  input  logic                   func,
  input  logic [15:0]            req_size,
  input  ffpa_pkg::ffpa_cmd_t    cmd,
  output ffpa_pkg::ffpa_sts_t    sts,
  output logic [15:0]            hit_addr
);
  localparam int unsigned FreeDepth = MaxParts + 1;
  localparam int unsigned CntW = $clog2(FreeDepth + 1);
  localparam int unsigned FIdxW = $clog2(FreeDepth);
  localparam int unsigned UIdxW = (MaxParts > 1) ? $clog2(MaxParts) : 1;

  logic [15:0] free_start [FreeDepth];
  logic [15:0] free_length [FreeDepth];
  logic [15:0] used_start [MaxParts];
  logic [15:0] used_length [MaxParts];
  logic [CntW-1:0] free_count;
  logic [CntW-1:0] used_count;
  logic            req_func;
  logic [15:0]     req_len;
  logic [CntW-1:0] idx;
  logic [CntW-1:0] hit_idx;

  // scan compare: allocate scans free table, free scans used table
  logic [FIdxW-1:0] fi;
  logic [UIdxW-1:0] ui;
  assign fi = idx[FIdxW-1:0];
  assign ui = idx[UIdxW-1:0];

  logic scan_done_c, scan_hit_c;
  always_comb begin
    scan_hit_c = 1'b0;
    if (req_func == ffpa_pkg::FUNC_ALLOC) begin
      scan_done_c = (idx >= free_count);
      if (!scan_done_c) scan_hit_c = (free_length[fi] >= req_len);
    end else begin
      scan_done_c = (idx >= used_count);
      if (!scan_done_c) scan_hit_c = (used_length[ui] == req_len);
    end
  end

  // insertion points, one combinational pass over the independent entries: free
  // side for the freed address, used side for the allocated one; only the chosen index matters
  logic [15:0] rel_addr;
  logic [FIdxW-1:0] hi_f;
  logic [UIdxW-1:0] hi_u;
  assign hi_f = hit_idx[FIdxW-1:0];
  assign hi_u = hit_idx[UIdxW-1:0];
  assign rel_addr = used_start[hi_u];

  logic [CntW-1:0] fpos;
  logic [CntW-1:0] upos;
  always_comb begin
    fpos = '0;
    for (int k = 0; k < FreeDepth; k++)
      if (CntW'(k) < free_count && free_start[k] < rel_addr) fpos = CntW'(k + 1);
    upos = '0;
    for (int k = 0; k < MaxParts; k++)
      if (CntW'(k) < used_count && used_start[k] < free_start[hi_f])
        upos = CntW'(k + 1);
  end

  logic [FIdxW-1:0] fp, fpm;
  assign fp  = fpos[FIdxW-1:0];
  assign fpm = FIdxW'(fpos - 1'b1);
  logic left_m, right_m;
  assign left_m  = (fpos != 0) && (16'(free_start[fpm] + free_length[fpm]) == rel_addr);
  assign right_m = (fpos < free_count) && (16'(rel_addr + req_len) == free_start[fp]);

  assign sts.scan_done  = scan_done_c;
  assign sts.scan_hit   = scan_hit_c;
  assign sts.used_full  = (used_count >= CntW'(MaxParts));
  assign sts.size_zero  = (req_len == '0);
  assign sts.is_free    = req_func;
  assign hit_addr = (req_func == ffpa_pkg::FUNC_ALLOC) ? free_start[hi_f] : rel_addr;

  // table update: a commit may shift the entries past the insertion or removal point by one place in parallel
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      free_start[0] <= '0;
      free_length[0] <= rst ? ffpa_pkg::ResetTotal : cfg_data;
      free_count <= (rst || cfg_data != '0) ? CntW'(1) : '0;
      used_count <= '0;
      idx <= '0;
    end else begin
      if (cmd.load) begin
        req_func <= func;
        req_len  <= req_size;
      end
      if (cmd.scan_reset) idx <= '0;
      else if (cmd.scan_step) idx <= idx + 1'b1;
      if (cmd.latch_hit) hit_idx <= idx;
      if (cmd.alloc_apply) begin
        for (int k = MaxParts - 1; k > 0; k--)
          if (CntW'(k) > upos) begin
            used_start[k]  <= used_start[k-1];
            used_length[k] <= used_length[k-1];
          end
        used_start[upos[UIdxW-1:0]]  <= free_start[hi_f];
        used_length[upos[UIdxW-1:0]] <= req_len;
        used_count <= used_count + 1'b1;
        if (free_length[hi_f] == req_len) begin
          for (int k = 0; k < FreeDepth - 1; k++)
            if (CntW'(k) >= hit_idx) begin
              free_start[k]  <= free_start[k+1];
              free_length[k] <= free_length[k+1];
            end
          free_count <= free_count - 1'b1;
        end else begin
          free_start[hi_f]  <= 16'(free_start[hi_f] + req_len);
          free_length[hi_f] <= 16'(free_length[hi_f] - req_len);
        end
      end
      if (cmd.free_apply) begin
        for (int k = 0; k < MaxParts - 1; k++)
          if (CntW'(k) >= hit_idx) begin
            used_start[k]  <= used_start[k+1];
            used_length[k] <= used_length[k+1];
          end
        used_count <= used_count - 1'b1;
        if (left_m && right_m) begin
          free_length[fpm] <= 16'(free_length[fpm] + req_len + free_length[fp]);
          for (int k = 0; k < FreeDepth - 1; k++)
            if (CntW'(k) >= fpos) begin
              free_start[k]  <= free_start[k+1];
              free_length[k] <= free_length[k+1];
            end
          free_count <= free_count - 1'b1;
        end else if (left_m) begin
          free_length[fpm] <= 16'(free_length[fpm] + req_len);
        end else if (right_m) begin
          free_start[fp]  <= rel_addr;
          free_length[fp] <= 16'(free_length[fp] + req_len);
        end else if (free_count < CntW'(FreeDepth)) begin
          for (int k = FreeDepth - 1; k > 0; k--)
            if (CntW'(k) > fpos) begin
              free_start[k]  <= free_start[k-1];
              free_length[k] <= free_length[k-1];
            end
          free_start[fp]  <= rel_addr;
          free_length[fp] <= req_len;
          free_count <= free_count + 1'b1;
        end
      end
    end
  end
endmodule

@@ hdl/ffpa_ctrl.sv @@
// Request sequencer: scan, commit on a hit, then present the result
module ffpa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  logic [15:0]         hit_addr,
  input  ffpa_pkg::ffpa_sts_t sts,
  output ffpa_pkg::ffpa_cmd_t cmd,
  output logic [1:0]          status,
  output logic [15:0]         address
);
  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY} state_t;
  state_t state;

  logic out_full;
  assign out_valid = out_full;
  assign in_stall  = (state != S_IDLE) || (out_full && out_stall);

  logic in_xfer;
  assign in_xfer = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    cmd.load = in_xfer;
    cmd.scan_reset = in_xfer;
    if (state == S_SCAN) begin
      cmd.scan_step = !sts.scan_hit && !sts.scan_done;
      cmd.latch_hit = sts.scan_hit;
    end
    if (state == S_APPLY) begin
      cmd.alloc_apply = !sts.is_free;
      cmd.free_apply  = sts.is_free;
    end
  end

  // state and registered result
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      if (out_full && !out_stall) out_full <= 1'b0;
      case (state)
        S_IDLE: if (in_xfer) state <= S_SCAN;
        S_SCAN: begin
          if (sts.size_zero || (!sts.is_free && sts.used_full)) begin
            status <= ffpa_pkg::ST_BAD; address <= '0; out_full <= 1'b1;
            state <= S_IDLE;
          end else if (sts.scan_hit) begin
            state <= S_APPLY;
          end else if (sts.scan_done) begin
            status <= sts.is_free ? ffpa_pkg::ST_NO_MATCH : ffpa_pkg::ST_NO_FIT;
            address <= '0; out_full <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_APPLY: begin
          status <= ffpa_pkg::ST_OK; address <= hit_addr; out_full <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ hdl/first_fit_partition_allocator.sv @@
// First-fit partition allocator. Each item runs a one-entry-per-cycle scan
// of the free table (allocate) or allocated table (free), over up to
// MAX_PARTITIONS + 1 table entries; a hit adds a commit step that updates
// both tables at once, and a size of zero or, on allocate, a full allocated
// table gives an error result from the scan state without a commit. One item
// is in work at a time; a new item is taken only once the last result has
// left or leaves in the same cycle, so output stalls hold off the input.
// A cfg_we write resets both tables.
`include "first_fit_partition_allocator_assert.svh"
module first_fit_partition_allocator #(
  parameter int unsigned MAX_PARTITIONS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [15:0] req_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] address
);
  ffpa_pkg::ffpa_cmd_t cmd;
  ffpa_pkg::ffpa_sts_t sts;
  logic [15:0] hit_addr;

  ffpa_datapath #(.MaxParts(MAX_PARTITIONS)) u_dp (
    .clk, .rst, .cfg_we, .cfg_data, .func, .req_size,
    .cmd, .sts, .hit_addr
  );

  ffpa_ctrl u_ctrl (
    .clk, .rst, .cfg_we, .in_valid, .in_stall, .out_valid, .out_stall,
    .hit_addr, .sts, .cmd, .status, .address
  );

  `FFPA_ASSERT_IMP(a_err_addr_zero, clk, rst, out_valid && status != ffpa_pkg::ST_OK,
    address == 16'd0, "error result with nonzero address")
  `FFPA_ASSERT_IMP(a_one_apply, clk, rst, cmd.alloc_apply || cmd.free_apply,
    !(cmd.alloc_apply && cmd.free_apply) && in_stall, "commit overlap")
  `FFPA_ASSERT_NEXT(a_accept_stalls, clk, rst, in_valid && !in_stall && !cfg_we,
    in_stall, "accepted while busy")
endmodule
